@@ rtl/core/rpid_pkg.sv @@
// Shared constants, types and the microcode program of the ramped PID speed loop.
package rpid_pkg;

  localparam int MOTOR_COUNT = 4;
  localparam int MOTOR_W     = $clog2(MOTOR_COUNT);
  localparam int DUTY_MAX    = 1000;
  localparam int DUTY_W      = 10;
  localparam int DUTY_HALF   = DUTY_MAX / 2;
  localparam int STEP_W      = 3;
  localparam int MUL_A_W     = 35;
  localparam int MUL_B_W     = 25;
  localparam int PROD_W      = 56;
  localparam int ACC_W       = 56;
  localparam int SUM_SHIFT   = 17;

  typedef enum logic [2:0] {
    CFG_ACCEL  = 3'd0,
    CFG_SCALE  = 3'd1,
    CFG_GAIN_P = 3'd2,
    CFG_GAIN_I = 3'd3,
    CFG_GAIN_D = 3'd4,
    CFG_MOTORS = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] accel_step;
    logic [23:0] speed_scale;
    logic [15:0] gain_p;
    logic [15:0] gain_i;
    logic [15:0] gain_d;
    logic [2:0]  motors_enabled;
  } cfg_t;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_MEAS = 3'd1,
    MUL_P    = 3'd2,
    MUL_I    = 3'd3,
    MUL_D    = 3'd4
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD  = 2'd0,
    ACC_LOAD2 = 2'd1,
    ACC_ADD1  = 2'd2,
    ACC_ADD2  = 2'd3
  } acc_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT     = 2'd0,
    JMP_NO_INPUT = 2'd1,
    JMP_BYPASS   = 2'd2,
    JMP_OUT_BUSY = 2'd3
  } jmp_e;

  localparam logic [STEP_W-1:0] ST_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] ST_MEAS  = 3'd1;
  localparam logic [STEP_W-1:0] ST_ERR   = 3'd2;
  localparam logic [STEP_W-1:0] ST_MUL_P = 3'd3;
  localparam logic [STEP_W-1:0] ST_MUL_I = 3'd4;
  localparam logic [STEP_W-1:0] ST_MUL_D = 3'd5;
  localparam logic [STEP_W-1:0] ST_SUM   = 3'd6;
  localparam logic [STEP_W-1:0] ST_FIN   = 3'd7;

  typedef struct packed {
    logic              in_ready;
    mul_sel_e          mul_sel;
    acc_op_e           acc_op;
    logic              ld_ramp;
    logic              ld_err;
    logic              finish;
    jmp_e              jmp;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic bypass;
    logic out_busy;
  } status_t;

  // Control store: one word per step. A taken jump loads the target, otherwise
  // the step counter advances (and wraps from the last step back to idle).
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      ST_IDLE: begin
        w.in_ready = 1'b1;
        w.jmp      = JMP_NO_INPUT;
        w.target   = ST_IDLE;
      end
      ST_MEAS: begin
        w.mul_sel = MUL_MEAS;
        w.ld_ramp = 1'b1;
        w.jmp     = JMP_BYPASS;
        w.target  = ST_FIN;
      end
      ST_ERR: begin
        w.ld_err = 1'b1;
      end
      ST_MUL_P: begin
        w.mul_sel = MUL_P;
      end
      ST_MUL_I: begin
        w.mul_sel = MUL_I;
        w.acc_op  = ACC_LOAD2;
      end
      ST_MUL_D: begin
        w.mul_sel = MUL_D;
        w.acc_op  = ACC_ADD1;
      end
      ST_SUM: begin
        w.acc_op = ACC_ADD2;
      end
      ST_FIN: begin
        w.finish = 1'b1;
        w.jmp    = JMP_OUT_BUSY;
        w.target = ST_FIN;
      end
      default: begin
        w = '0;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/rpid_seq.sv @@
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module rpid_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rpid_pkg::status_t status_i,
  output rpid_pkg::ctrl_t   ctrl_o
);

  logic [rpid_pkg::STEP_W-1:0] step_q, step_d;
  logic                        take;

  assign ctrl_o = rpid_pkg::ucode(step_q);

  always_comb begin
    case (ctrl_o.jmp)
      rpid_pkg::JMP_NEXT:     take = 1'b0;
      rpid_pkg::JMP_NO_INPUT: take = ~status_i.in_valid;
      rpid_pkg::JMP_BYPASS:   take = status_i.bypass;
      rpid_pkg::JMP_OUT_BUSY: take = status_i.out_busy;
      default:                take = 1'b0;
    endcase
    step_d = take ? ctrl_o.target : step_q + rpid_pkg::STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= rpid_pkg::ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ rtl/core/rpid_dp.sv @@
// Datapath: per-motor state, ramp, shared multiplier, accumulator and result register.
module rpid_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rpid_pkg::ctrl_t   ctrl_i,
  input  rpid_pkg::cfg_t    cfg_i,
  output rpid_pkg::status_t status_o,
  input  logic              s_axis_tvalid,
  input  logic [47:0]       s_axis_tdata,
  input  logic [2:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,
  output logic [2:0]        m_axis_tuser
);

  localparam int MC = rpid_pkg::MOTOR_COUNT;
  localparam int MW = rpid_pkg::MOTOR_W;
  localparam int DW = rpid_pkg::DUTY_W;
  localparam logic signed [17:0] DUTY_MAX_S = 18'(rpid_pkg::DUTY_MAX);
  localparam logic [DW-1:0] DUTY_HALF_V = DW'(rpid_pkg::DUTY_HALF);
  localparam logic [DW-1:0] DUTY_MAX_V  = DW'(rpid_pkg::DUTY_MAX);
  localparam logic signed [rpid_pkg::ACC_W-1:0] TRUNC_BIAS =
    {{(rpid_pkg::ACC_W - rpid_pkg::SUM_SHIFT){1'b0}}, {rpid_pkg::SUM_SHIFT{1'b1}}};

  // Latched input item
  logic [MW-1:0]      m_q;
  logic signed [15:0] tgt_q;
  logic [31:0]        enc_q;
  logic               restart_q;

  // Per-motor state
  logic signed [15:0] ramp_st_q [MC];
  logic [31:0]        base_st_q [MC];
  logic signed [31:0] e1_st_q   [MC];
  logic signed [31:0] e2_st_q   [MC];
  logic [DW-1:0]      duty_st_q [MC];

  // Working registers
  logic signed [15:0]                  ramp_q;
  logic signed [31:0]                  e_q;
  logic signed [15:0]                  meas_q;
  logic signed [rpid_pkg::PROD_W-1:0]  prod_q;
  logic signed [rpid_pkg::ACC_W-1:0]   acc_q;

  // Result register
  logic               out_valid_q;
  logic [MW-1:0]      out_m_q;
  logic [DW-1:0]      out_duty_q;
  logic [15:0]        out_ramp_q;
  logic [15:0]        out_meas_q;
  logic               out_reg_q;

  logic accept, fire, m_ok, m_en;
  assign accept = s_axis_tvalid & ctrl_i.in_ready;
  assign m_ok   = 32'(m_q) < MC;
  assign m_en   = {1'b0, m_q} < cfg_i.motors_enabled;
  assign fire   = ctrl_i.finish & (~out_valid_q | m_axis_tready);

  assign status_o.in_valid = s_axis_tvalid;
  assign status_o.bypass   = ~m_ok | ~m_en | restart_q;
  assign status_o.out_busy = out_valid_q & ~m_axis_tready;

  // Ramp toward the target by at most accel_step.
  logic signed [15:0] ramp_cur, ramp_n;
  logic signed [17:0] ramp_x, tgt_x, accel_x, ramp_up, ramp_dn;
  always_comb begin
    ramp_cur = ramp_st_q[m_q];
    ramp_x   = {{2{ramp_cur[15]}}, ramp_cur};
    tgt_x    = {{2{tgt_q[15]}}, tgt_q};
    accel_x  = $signed({2'b00, cfg_i.accel_step});
    ramp_up  = ramp_x + accel_x;
    ramp_dn  = ramp_x - accel_x;
    if (ramp_cur < tgt_q) begin
      ramp_n = (ramp_up > tgt_x) ? tgt_q : ramp_up[15:0];
    end else if (ramp_cur > tgt_q) begin
      ramp_n = (ramp_dn < tgt_x) ? tgt_q : ramp_dn[15:0];
    end else begin
      ramp_n = ramp_cur;
    end
  end

  // Shared multiplier operands
  logic signed [31:0]                  delta;
  logic signed [rpid_pkg::MUL_A_W-1:0] delta_x, e_x, e1_x, e2_x, d_p, d_i, d_d, mul_a;
  logic signed [rpid_pkg::MUL_B_W-1:0] mul_b;
  logic signed [rpid_pkg::MUL_A_W+rpid_pkg::MUL_B_W-1:0] prod_full;
  always_comb begin
    delta   = $signed(enc_q - base_st_q[m_q]);
    delta_x = rpid_pkg::MUL_A_W'(delta);
    e_x     = rpid_pkg::MUL_A_W'(e_q);
    e1_x    = rpid_pkg::MUL_A_W'(e1_st_q[m_q]);
    e2_x    = rpid_pkg::MUL_A_W'(e2_st_q[m_q]);
    d_p     = e_x - e1_x;
    d_i     = e_x + e1_x;
    d_d     = e_x - (e1_x <<< 1) + e2_x;
    case (ctrl_i.mul_sel)
      rpid_pkg::MUL_MEAS: begin
        mul_a = delta_x;
        mul_b = $signed({1'b0, cfg_i.speed_scale});
      end
      rpid_pkg::MUL_P: begin
        mul_a = d_p;
        mul_b = {{9{cfg_i.gain_p[15]}}, cfg_i.gain_p};
      end
      rpid_pkg::MUL_I: begin
        mul_a = d_i;
        mul_b = {{9{cfg_i.gain_i[15]}}, cfg_i.gain_i};
      end
      rpid_pkg::MUL_D: begin
        mul_a = d_d;
        mul_b = {{9{cfg_i.gain_d[15]}}, cfg_i.gain_d};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_full = mul_a * mul_b;
  end

  // Error in Q.8 and measured whole speed, both saturated.
  logic signed [47:0] meas_q8;
  logic signed [48:0] diff;
  logic signed [31:0] e_n;
  logic [39:0]        meas_whole;
  logic signed [15:0] meas_n;
  always_comb begin
    meas_q8    = prod_q[55:8];
    diff       = $signed({{25{ramp_q[15]}}, ramp_q, 8'h00}) -
                 $signed({meas_q8[47], meas_q8});
    if ((&diff[48:31]) | ~(|diff[48:31])) begin
      e_n = diff[31:0];
    end else begin
      e_n = diff[48] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    meas_whole = prod_q[55:16];
    if ((&meas_whole[39:15]) | ~(|meas_whole[39:15])) begin
      meas_n = meas_whole[15:0];
    end else begin
      meas_n = meas_whole[39] ? 16'sh8000 : 16'sh7FFF;
    end
  end

  // Duty update: sum / 2^17 toward zero, saturate to int16, clamp to 0..max.
  logic signed [rpid_pkg::ACC_W-1:0] acc_adj;
  logic [38:0]        q_sum;
  logic signed [15:0] pd;
  logic signed [17:0] dsum;
  logic [DW-1:0]      duty_cur, duty_n;
  always_comb begin
    acc_adj  = acc_q + (acc_q[rpid_pkg::ACC_W-1] ? TRUNC_BIAS : '0);
    q_sum    = acc_adj[rpid_pkg::ACC_W-1:rpid_pkg::SUM_SHIFT];
    if ((&q_sum[38:15]) | ~(|q_sum[38:15])) begin
      pd = q_sum[15:0];
    end else begin
      pd = q_sum[38] ? 16'sh8000 : 16'sh7FFF;
    end
    duty_cur = duty_st_q[m_q];
    dsum     = $signed({{(18 - DW){1'b0}}, duty_cur}) + $signed({{2{pd[15]}}, pd});
    if (dsum < 0) begin
      duty_n = '0;
    end else if (dsum > DUTY_MAX_S) begin
      duty_n = DUTY_MAX_V;
    end else begin
      duty_n = dsum[DW-1:0];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      m_q       <= s_axis_tuser[MW-1:0];
      restart_q <= s_axis_tuser[2];
      tgt_q     <= s_axis_tdata[15:0];
      enc_q     <= s_axis_tdata[47:16];
    end
    if (ctrl_i.ld_ramp) begin
      ramp_q <= ramp_n;
    end
    if (ctrl_i.mul_sel != rpid_pkg::MUL_NONE) begin
      prod_q <= prod_full[rpid_pkg::PROD_W-1:0];
    end
    if (ctrl_i.ld_err) begin
      e_q    <= e_n;
      meas_q <= meas_n;
    end
    case (ctrl_i.acc_op)
      rpid_pkg::ACC_LOAD2: acc_q <= prod_q <<< 1;
      rpid_pkg::ACC_ADD1:  acc_q <= acc_q + prod_q;
      rpid_pkg::ACC_ADD2:  acc_q <= acc_q + (prod_q <<< 1);
      default:             acc_q <= acc_q;
    endcase
    if (fire) begin
      out_m_q <= m_q;
      if (!m_ok) begin
        out_duty_q <= '0;
        out_ramp_q <= '0;
        out_meas_q <= '0;
        out_reg_q  <= 1'b0;
      end else if (!m_en) begin
        out_duty_q <= duty_cur;
        out_ramp_q <= ramp_cur;
        out_meas_q <= '0;
        out_reg_q  <= 1'b0;
      end else if (restart_q) begin
        out_duty_q <= DUTY_HALF_V;
        out_ramp_q <= '0;
        out_meas_q <= '0;
        out_reg_q  <= 1'b0;
      end else begin
        out_duty_q <= duty_n;
        out_ramp_q <= ramp_q;
        out_meas_q <= meas_q;
        out_reg_q  <= 1'b1;
      end
    end
  end

  // Per-motor state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < MC; i++) begin
        ramp_st_q[i] <= '0;
        base_st_q[i] <= '0;
        e1_st_q[i]   <= '0;
        e2_st_q[i]   <= '0;
        duty_st_q[i] <= DUTY_HALF_V;
      end
    end else begin
      if (fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      if (fire && m_ok && m_en) begin
        base_st_q[m_q] <= enc_q;
        if (restart_q) begin
          ramp_st_q[m_q] <= '0;
          e1_st_q[m_q]   <= '0;
          e2_st_q[m_q]   <= '0;
          duty_st_q[m_q] <= DUTY_HALF_V;
        end else begin
          ramp_st_q[m_q] <= ramp_q;
          e1_st_q[m_q]   <= e_q;
          e2_st_q[m_q]   <= e1_st_q[m_q];
          duty_st_q[m_q] <= duty_n;
        end
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_meas_q, out_ramp_q, out_duty_q};
  assign m_axis_tuser  = {out_reg_q, out_m_q};

endmodule

@@ rtl/core/ramped_incremental_pid_speed_loop.sv @@
// Top level of the ramped incremental PID speed loop: configuration registers and core.
// Each accepted transfer is one control tick for one motor. A regulated tick runs the measure,
// error, P, I, D, sum and finish steps before its result is loaded into the output register,
// because one shared multiplier is used four times in the microcode program (encoder delta times
// scale, then the P, I and D terms); a restart tick or a tick for a motor that is not enabled
// runs only the measure and finish steps. The next transfer is accepted in the idle step after
// the result is loaded, even while it still waits in the output register. Configuration
// writes are always ready and must be made only while no tick is in flight. The ramp, encoder
// baseline, error history and duty of every motor are held in flip-flops and reset at once.
module ramped_incremental_pid_speed_loop (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // target_speed[15:0], encoder_count[47:16]
  input  logic [2:0]  s_axis_tuser,   // motor[1:0], restart[2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // duty[9:0], ramped_speed[25:10], measured_speed[41:26]
  output logic [2:0]  m_axis_tuser,   // motor_out[1:0], regulated[2]
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  rpid_pkg::cfg_t    cfg_q;
  rpid_pkg::ctrl_t   ctrl;
  rpid_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        rpid_pkg::CFG_ACCEL:  cfg_q.accel_step     <= cfg_data_i[15:0];
        rpid_pkg::CFG_SCALE:  cfg_q.speed_scale    <= cfg_data_i;
        rpid_pkg::CFG_GAIN_P: cfg_q.gain_p         <= cfg_data_i[15:0];
        rpid_pkg::CFG_GAIN_I: cfg_q.gain_i         <= cfg_data_i[15:0];
        rpid_pkg::CFG_GAIN_D: cfg_q.gain_d         <= cfg_data_i[15:0];
        rpid_pkg::CFG_MOTORS: cfg_q.motors_enabled <= cfg_data_i[2:0];
        default:              cfg_q                <= cfg_q;
      endcase
    end
  end

  rpid_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  rpid_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cfg_i         (cfg_q),
    .status_o      (status),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  assign s_axis_tready = ctrl.in_ready;

  // A tick in flight blocks the next one.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a tick is still in flight");

  // A new result only appears after the finishing step of the program.
  a_result_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctrl.finish))
    else $error("result appeared outside the finishing step");

  // Duty never leaves its clamp range.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[9:0] <= rpid_pkg::DUTY_MAX))
    else $error("duty above maximum");

  // Measured speed is reported only when the loop ran.
  a_meas_unregulated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[2]) |-> (m_axis_tdata[41:26] == 16'h0000))
    else $error("measured speed set on an unregulated result");

endmodule

@@ tb/ramped_incremental_pid_speed_loop_tb.sv @@
// Self-checking testbench for the ramped incremental PID speed loop, with its own loop predictor.
`timescale 1ns / 100ps

module ramped_incremental_pid_speed_loop_tb;

  localparam int     SETTLE_CYCLES = 10;
  localparam int     LONG_HOLD     = 300;
  localparam int     PHASES        = 6;
  localparam int     TICKS_PER_PH  = 150;
  localparam longint ERR_MIN       = -(64'sd1 <<< 31);
  localparam longint ERR_MAX       = (64'sd1 <<< 31) - 1;

  typedef struct packed {
    logic [1:0]  motor;
    logic [15:0] target;
    logic [31:0] encoder;
    logic        restart;
  } speed_tick_t;

  typedef struct packed {
    logic [1:0]  motor;
    logic [9:0]  duty;
    logic [15:0] ramp;
    logic [15:0] meas;
    logic        regulated;
  } speed_result_t;

  typedef struct packed {
    logic [15:0] accel;
    logic [23:0] scale;
    logic [15:0] kp;
    logic [15:0] ki;
    logic [15:0] kd;
    logic [2:0]  motors;
  } speed_settings_t;

  typedef struct packed {
    int          preset;
    speed_tick_t tick;
    int          gold_duty;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [23:0] cfg_data_i = '0;

  // Predictor copy of the configuration and of the per-motor loop state.
  logic [15:0] accel_lim = '0;
  logic [23:0] scale_q16 = '0;
  shortint     kp = 0, ki = 0, kd = 0;
  logic [2:0]  motors_on = '0;
  shortint     ramp_now  [rpid_pkg::MOTOR_COUNT];
  logic [31:0] enc_base  [rpid_pkg::MOTOR_COUNT];
  int          err_prev  [rpid_pkg::MOTOR_COUNT];
  int          err_prev2 [rpid_pkg::MOTOR_COUNT];
  int          duty_now  [rpid_pkg::MOTOR_COUNT];
  logic [31:0] enc_pos   [rpid_pkg::MOTOR_COUNT];

  speed_result_t   results_due [$];
  dir_row_t        dir_rows [$];
  speed_settings_t presets [4];
  int              mismatches = 0;
  int              send_idle_pct = 0;
  int              recv_stall_pct = 0;
  int              holds_asked = 0;
  int              holds_served = 0;
  int              stall_left = 0;

  ramped_incremental_pid_speed_loop uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic longint clamp(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  // One control tick: updates the predicted motor state and returns the expected result.
  function automatic speed_result_t run_speed_loop(input speed_tick_t t);
    speed_result_t r;
    int     m;
    int     d32;
    longint acc, ramp, tgt, meas, e, e1, e2, sum, step, duty;
    r = '0;
    m = t.motor;
    r.motor = t.motor;
    if (m >= motors_on) begin
      r.duty = 10'(duty_now[m]);
      r.ramp = 16'(ramp_now[m]);
      return r;
    end
    if (t.restart) begin
      enc_base[m]  = t.encoder;
      err_prev[m]  = 0;
      err_prev2[m] = 0;
      ramp_now[m]  = 0;
      duty_now[m]  = rpid_pkg::DUTY_HALF;
      r.duty = 10'(rpid_pkg::DUTY_HALF);
      return r;
    end
    acc  = accel_lim;
    ramp = ramp_now[m];
    tgt  = $signed(t.target);
    if (ramp < tgt) begin
      ramp = ramp + acc;
      if (ramp > tgt) ramp = tgt;
    end else if (ramp > tgt) begin
      ramp = ramp - acc;
      if (ramp < tgt) ramp = tgt;
    end
    // The encoder delta wraps at 32 bits before it is scaled.
    d32  = t.encoder - enc_base[m];
    meas = (longint'(d32) * longint'(scale_q16)) >>> 8;
    e    = clamp(ramp * 256 - meas, ERR_MIN, ERR_MAX);
    e1   = err_prev[m];
    e2   = err_prev2[m];
    sum  = 2 * kp * (e - e1) + ki * (e + e1) + 2 * kd * (e - 2 * e1 + e2);
    step = (sum >= 0) ? (sum >>> 17) : -((-sum) >>> 17);
    step = clamp(step, -32768, 32767);
    duty = clamp(duty_now[m] + step, 0, rpid_pkg::DUTY_MAX);
    duty_now[m]  = int'(duty);
    err_prev2[m] = int'(e1);
    err_prev[m]  = int'(e);
    enc_base[m]  = t.encoder;
    ramp_now[m]  = shortint'(ramp);
    r.duty      = 10'(duty);
    r.ramp      = 16'(ramp);
    r.meas      = 16'(clamp(meas >>> 8, -32768, 32767));
    r.regulated = 1'b1;
    return r;
  endfunction

  function automatic logic [15:0] random_gain();
    if ($urandom_range(99) < 15) return 16'($urandom);
    return 16'(int'($urandom_range(1024)) - 512);
  endfunction

  function automatic speed_settings_t random_settings();
    speed_settings_t s;
    s.accel  = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(2000));
    s.scale  = ($urandom_range(4) == 0) ? 24'($urandom)
                                        : 24'($urandom_range(24'h040000, 24'h004000));
    s.kp     = random_gain();
    s.ki     = random_gain();
    s.kd     = random_gain();
    s.motors = ($urandom_range(99) < 70) ? 3'd4 : 3'($urandom_range(7));
    return s;
  endfunction

  // Encoders mostly advance by a plausible velocity; now and then they jump anywhere.
  function automatic speed_tick_t random_tick();
    speed_tick_t t;
    int pick;
    t.motor = 2'($urandom_range(3));
    pick = $urandom_range(99);
    if (pick < 80) t.target = 16'(int'($urandom_range(6000)) - 3000);
    else if (pick < 87) t.target = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    else t.target = 16'($urandom);
    if ($urandom_range(99) < 94) enc_pos[t.motor] += int'($urandom_range(600)) - 300;
    else enc_pos[t.motor] = $urandom;
    t.encoder = enc_pos[t.motor];
    t.restart = ($urandom_range(99) < 4);
    return t;
  endfunction

  task automatic add_row(input int preset, input logic [1:0] m, input logic [15:0] tgt,
                         input logic [31:0] enc, input logic rs, input int gold_duty);
    dir_row_t r;
    r.preset    = preset;
    r.tick      = '{motor: m, target: tgt, encoder: enc, restart: rs};
    r.gold_duty = gold_duty;
    dir_rows.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic cfg_write(input rpid_pkg::cfg_reg_e idx, input logic [23:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (cfg_ready_o !== 1'b1) @(posedge clk_i);
    case (idx)
      rpid_pkg::CFG_ACCEL:  accel_lim = val[15:0];
      rpid_pkg::CFG_SCALE:  scale_q16 = val;
      rpid_pkg::CFG_GAIN_P: kp = shortint'(val[15:0]);
      rpid_pkg::CFG_GAIN_I: ki = shortint'(val[15:0]);
      rpid_pkg::CFG_GAIN_D: kd = shortint'(val[15:0]);
      rpid_pkg::CFG_MOTORS: motors_on = val[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input speed_settings_t s);
    cfg_write(rpid_pkg::CFG_ACCEL, 24'(s.accel));
    cfg_write(rpid_pkg::CFG_SCALE, s.scale);
    cfg_write(rpid_pkg::CFG_GAIN_P, 24'(s.kp));
    cfg_write(rpid_pkg::CFG_GAIN_I, 24'(s.ki));
    cfg_write(rpid_pkg::CFG_GAIN_D, 24'(s.kd));
    cfg_write(rpid_pkg::CFG_MOTORS, 24'(s.motors));
    cfg_valid_i <= 1'b0;
  endtask

  // Valid is left high after a transfer; the next call either idles or offers a new tick.
  task automatic send_tick(input speed_tick_t t, input speed_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {t.encoder, t.target};
    s_axis_tuser  <= {t.restart, t.motor};
    @(posedge clk_i);
    while (s_axis_tready !== 1'b1) @(posedge clk_i);
    results_due.push_back(want);
  endtask

  task automatic wait_results_done();
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic check_result();
    speed_result_t got, want;
    got.motor     = m_axis_tuser[1:0];
    got.regulated = m_axis_tuser[2];
    got.duty      = m_axis_tdata[9:0];
    got.ramp      = m_axis_tdata[25:10];
    got.meas      = m_axis_tdata[41:26];
    if (results_due.size() == 0) begin
      report_mismatch("unrequested result, duty", got.duty, 0);
    end else begin
      want = results_due.pop_front();
      if (got.motor !== want.motor) report_mismatch("motor_out", got.motor, want.motor);
      if (got.duty !== want.duty) report_mismatch("duty", got.duty, want.duty);
      if (got.ramp !== want.ramp) report_mismatch("ramped_speed", got.ramp, want.ramp);
      if (got.meas !== want.meas) report_mismatch("measured_speed", got.meas, want.meas);
      if (got.regulated !== want.regulated)
        report_mismatch("regulated", got.regulated, want.regulated);
    end
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) check_result();
    if (holds_served != holds_asked) begin
      holds_served++;
      stall_left = LONG_HOLD;
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("ramped_incremental_pid_speed_loop_tb NOT OK");
    $finish;
  end

  initial begin
    speed_tick_t   t;
    speed_result_t want;
    dir_row_t      r;
    for (int i = 0; i < rpid_pkg::MOTOR_COUNT; i++) begin
      ramp_now[i]  = 0;
      enc_base[i]  = '0;
      err_prev[i]  = 0;
      err_prev2[i] = 0;
      duty_now[i]  = rpid_pkg::DUTY_HALF;
      enc_pos[i]   = $urandom;
    end
    presets[0] = '{accel: 16'd100, scale: 24'h010000, kp: 16'd256, ki: 16'd128,
                   kd: 16'd64, motors: 3'd4};
    presets[1] = '{accel: 16'hFFFF, scale: 24'hFFFFFF, kp: 16'h7FFF, ki: 16'h7FFF,
                   kd: 16'h7FFF, motors: 3'd7};
    presets[2] = '{accel: 16'd0, scale: 24'h000000, kp: 16'h8000, ki: 16'h8000,
                   kd: 16'h8000, motors: 3'd2};
    presets[3] = '{accel: 16'd1, scale: 24'h000100, kp: 16'd0, ki: 16'd256,
                   kd: 16'd0, motors: 3'd1};

    // Out of reset no motor is enabled, so every tick echoes the reset state.
    add_row(-1, 2'd0, 16'h7FFF, 32'h7FFFFFFF, 1'b0, rpid_pkg::DUTY_HALF);
    add_row(-1, 2'd3, 16'h8000, 32'h80000000, 1'b1, rpid_pkg::DUTY_HALF);
    add_row(-1, 2'd1, 16'h0000, 32'hFFFFFFFF, 1'b0, rpid_pkg::DUTY_HALF);
    add_row(0, 2'd0, 16'h0000, 32'h7FFFFFF0, 1'b1, rpid_pkg::DUTY_HALF);
    add_row(-1, 2'd0, 16'd1000, 32'h80000010, 1'b0, -1);
    add_row(-1, 2'd0, 16'd1000, 32'h80000030, 1'b0, -1);
    add_row(-1, 2'd0, 16'(-1000), 32'h80000020, 1'b0, -1);
    add_row(-1, 2'd1, 16'd50, 32'h00000005, 1'b0, -1);
    add_row(-1, 2'd2, 16'h8000, 32'hFFFFFF00, 1'b0, -1);
    add_row(-1, 2'd3, 16'h7FFF, 32'h00000000, 1'b0, -1);
    add_row(1, 2'd0, 16'h0000, 32'h00000000, 1'b1, rpid_pkg::DUTY_HALF);
    add_row(-1, 2'd0, 16'h7FFF, 32'h7FFFFFFF, 1'b0, -1);
    add_row(-1, 2'd0, 16'h8000, 32'h80000000, 1'b0, -1);
    add_row(-1, 2'd3, 16'h8000, 32'h00000000, 1'b0, -1);
    add_row(-1, 2'd1, 16'h7FFF, 32'h80000000, 1'b0, -1);
    add_row(2, 2'd0, 16'd1234, 32'd12345, 1'b0, -1);
    add_row(-1, 2'd1, 16'hFFFF, 32'h00000000, 1'b0, -1);
    add_row(-1, 2'd2, 16'd100, 32'h00000007, 1'b1, -1);
    add_row(-1, 2'd3, 16'h0000, 32'h00000000, 1'b0, -1);
    add_row(3, 2'd0, 16'd3, 32'd100, 1'b0, -1);
    add_row(-1, 2'd1, 16'd3, 32'd200, 1'b0, -1);
    add_row(-1, 2'd0, 16'h0000, 32'h5A5AA5A5, 1'b1, rpid_pkg::DUTY_HALF);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < dir_rows.size(); i++) begin
      r = dir_rows[i];
      if (r.preset >= 0) begin
        wait_results_done();
        apply_settings(presets[r.preset]);
      end
      want = run_speed_loop(r.tick);
      if (r.gold_duty >= 0)
        want = '{motor: r.tick.motor, duty: 10'(r.gold_duty), ramp: '0, meas: '0,
                 regulated: 1'b0};
      send_tick(r.tick, want);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_results_done();
      apply_settings(random_settings());
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 74;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 74;
        end
        default: begin
          send_idle_pct  = 37;
          recv_stall_pct = 37;
        end
      endcase
      for (int n = 0; n < TICKS_PER_PH; n++) begin
        // Back pressure fills the output register and stalls the input; later a full drain.
        if (ph == 4 && n == 40) holds_asked++;
        if (ph == 4 && n == 100) wait_results_done();
        t = random_tick();
        want = run_speed_loop(t);
        send_tick(t, want);
      end
    end

    wait_results_done();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("ramped_incremental_pid_speed_loop_tb OK");
    end else begin
      $display("ramped_incremental_pid_speed_loop_tb NOT OK");
    end
    $finish;
  end

endmodule
